FILE: hw/rtl/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// Holds the result codes, the walk state record and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

	// Address and entry widths.
	localparam int unsigned PA_W    = 52;
	localparam int unsigned VA_W    = 48;
	localparam int unsigned ENTRY_W = 64;
	localparam int unsigned FLAG_W  = 12;

	// Walk levels: top table, PDPT, page directory, page table.
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	// Entry bit positions.
	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_SIZE    = 7;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_READ = 2'd0,
		KIND_DONE = 2'd1,
		KIND_IDLE = 2'd2
	} kind_t;

	// Walk state carried from one word to the next.
	typedef struct packed {
		logic            busy;
		logic [1:0]      level;
		logic [VA_W-1:0] saved_virt;
	} walk_state_t;

	// One result word.
	typedef struct packed {
		kind_t             kind;
		logic [PA_W-1:0]   mem_addr;
		logic [PA_W-1:0]   phys_addr;
		logic [FLAG_W-1:0] flags_low;
		logic [FLAG_W-1:0] flags_high;
		logic              fault;
		logic              huge_page;
	} walk_result_t;

endpackage : ptw_pkg

`default_nettype wire

FILE: hw/rtl/ptw_step.sv
// One walk step: decodes an input word against the current walk state.
// Produces the next walk state and the result word, purely combinational.
// Depends on ptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptw_step
	import ptw_pkg::*;
(
	input  wire logic                 req_type,
	input  wire logic [VA_W-1:0]      virt_addr,
	input  wire logic [ENTRY_W-1:0]   entry_data,
	input  wire logic [PA_W-1:0]      root_base,
	input  wire walk_state_t          cur,
	output walk_state_t               nxt,
	output walk_result_t              res
);

	logic [1:0] next_level;
	logic [8:0] next_index;
	logic       present;
	logic       size_bit;

	assign present    = entry_data[BIT_PRESENT];
	assign size_bit   = entry_data[BIT_SIZE];
	assign next_level = cur.level + 2'd1;

	// Table index for the level that the next read goes to.
	always_comb begin
		unique case (next_level)
			LVL_PDPT: next_index = cur.saved_virt[38:30];
			LVL_PD:   next_index = cur.saved_virt[29:21];
			LVL_PT:   next_index = cur.saved_virt[20:12];
			default:  next_index = cur.saved_virt[47:39];
		endcase
	end

	// Step decode: new request, stray entry, fault, huge page, leaf, or descend.
	always_comb begin
		nxt            = cur;
		res.kind       = KIND_READ;
		res.mem_addr   = '0;
		res.phys_addr  = '0;
		res.flags_low  = '0;
		res.flags_high = '0;
		res.fault      = 1'b0;
		res.huge_page  = 1'b0;
		priority if (!req_type) begin
			// A new request abandons any walk in progress.
			nxt.busy       = 1'b1;
			nxt.level      = LVL_PML4;
			nxt.saved_virt = virt_addr;
			res.mem_addr   = {root_base[51:12], virt_addr[47:39], 3'b000};
		end else if (!cur.busy) begin
			res.kind = KIND_IDLE;
		end else if (!present) begin
			nxt.busy  = 1'b0;
			nxt.level = LVL_PML4;
			res.kind  = KIND_DONE;
			res.fault = 1'b1;
			if (cur.level == LVL_PT) begin
				res.flags_low  = entry_data[11:0];
				res.flags_high = entry_data[63:52];
			end
		end else if (cur.level == LVL_PD && size_bit) begin
			nxt.busy       = 1'b0;
			nxt.level      = LVL_PML4;
			res.kind       = KIND_DONE;
			res.phys_addr  = {entry_data[51:21], cur.saved_virt[20:0]};
			res.flags_low  = entry_data[11:0];
			res.flags_high = entry_data[63:52];
			res.huge_page  = 1'b1;
		end else if (cur.level == LVL_PT) begin
			nxt.busy       = 1'b0;
			nxt.level      = LVL_PML4;
			res.kind       = KIND_DONE;
			res.phys_addr  = {entry_data[51:12], cur.saved_virt[11:0]};
			res.flags_low  = entry_data[11:0];
			res.flags_high = entry_data[63:52];
		end else begin
			nxt.level    = next_level;
			res.mem_addr = {entry_data[51:12], next_index, 3'b000};
		end
	end

endmodule : ptw_step

`default_nettype wire

FILE: hw/rtl/four_level_page_table_walker_core.sv
// Top level of the four-level page table walker.
// Holds the root base register, the walk state and the output word register.
// Depends on ptw_pkg and ptw_step.
//
//  Channel  | Handshake            | Word
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | req_type, virt_addr, entry_data
//  out      | out_valid/ out_ready | out_kind, mem_addr, phys_addr, flags, fault,
//           |                      | huge_page
//  cfg      | cfg_wr_en            | cfg_wr_data (root table base)
//
// Each input word yields exactly one output word, which appears in the cycle after acceptance.
// A new word is taken every cycle while the output register is empty or drained
// in the same cycle; the combinational step logic sets the one-word-per-cycle rate.
// A stall on the output holds in_ready low until the waiting word is taken.
// Reset clears the walk to idle at the top level and the root base to zero.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_core
	import ptw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                req_type,
	input  wire logic [VA_W-1:0]     virt_addr,
	input  wire logic [ENTRY_W-1:0]  entry_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               out_kind,
	output logic [PA_W-1:0]          mem_addr,
	output logic [PA_W-1:0]          phys_addr,
	output logic [FLAG_W-1:0]        flags_low,
	output logic [FLAG_W-1:0]        flags_high,
	output logic                     fault,
	output logic                     huge_page,
	input  wire logic                cfg_wr_en,
	input  wire logic [PA_W-1:0]     cfg_wr_data
);

	logic [PA_W-1:0] root_base_q;
	walk_state_t     state_q;
	walk_state_t     state_nxt;
	walk_result_t    res_nxt;
	walk_result_t    res_q;
	logic            out_valid_q;
	logic            accept;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_base_q <= '0;
		end else if (cfg_wr_en) begin
			root_base_q <= cfg_wr_data;
		end
	end

	// The output register drains in the same cycle that it refills.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ptw_step u_step (
		.req_type   (req_type),
		.virt_addr  (virt_addr),
		.entry_data (entry_data),
		.root_base  (root_base_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Walk state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = res_q.kind;
	assign mem_addr   = res_q.mem_addr;
	assign phys_addr  = res_q.phys_addr;
	assign flags_low  = res_q.flags_low;
	assign flags_high = res_q.flags_high;
	assign fault      = res_q.fault;
	assign huge_page  = res_q.huge_page;

`ifndef SYNTHESIS
	// An idle walker always sits at the top level.
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.busy |-> state_q.level == LVL_PML4)
		else $error("idle walker not at top level");

	// A request starts a fresh walk at the top level.
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !req_type |=> state_q.busy && state_q.level == LVL_PML4)
		else $error("request did not start a walk");

	// Any entry at the page table level ends the walk.
	a_leaf_ends: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type && state_q.busy && state_q.level == LVL_PT |=> !state_q.busy)
		else $error("walk continued past the page table level");

	// A fault never reports a translated address or a huge page.
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.fault |-> res_q.phys_addr == '0 && !res_q.huge_page
			&& res_q.kind == KIND_DONE)
		else $error("fault word carries a translation");

	// Only finished walks carry the huge page mark.
	a_huge_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.huge_page |-> res_q.kind == KIND_DONE)
		else $error("huge page mark on a non-final word");
`endif

endmodule : four_level_page_table_walker_core

`default_nettype wire

FILE: tb/ptw_walk_checker.sv
// Checker for the four-level page table walker: watches both word channels and
// the root base write port, predicts each result word and compares it.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_walk_checker
	import ptw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic                req_type,
	input  wire logic [VA_W-1:0]     virt_addr,
	input  wire logic [ENTRY_W-1:0]  entry_data,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire logic [1:0]          out_kind,
	input  wire logic [PA_W-1:0]     mem_addr,
	input  wire logic [PA_W-1:0]     phys_addr,
	input  wire logic [FLAG_W-1:0]   flags_low,
	input  wire logic [FLAG_W-1:0]   flags_high,
	input  wire logic                fault,
	input  wire logic                huge_page,
	input  wire logic                cfg_wr_en,
	input  wire logic [PA_W-1:0]     cfg_wr_data,
	output int                       fail_count,
	output int                       words_pending
);

	// Predicted walk state and the root table base.
	logic             pred_busy;
	logic [1:0]       pred_level;
	logic [VA_W-1:0]  pred_virt;
	logic [PA_W-1:0]  pred_root;
	walk_result_t     expected_words[$];
	int               mismatches;

	assign fail_count = mismatches;

	// The nine-bit table index that the given level takes from the address.
	function automatic logic [8:0] table_index(input logic [VA_W-1:0] va, input logic [1:0] lvl);
		case (lvl)
			LVL_PML4: return va[47:39];
			LVL_PDPT: return va[38:30];
			LVL_PD:   return va[29:21];
			default:  return va[20:12];
		endcase
	endfunction

	// Advances the predicted walk by one input word and returns the result word.
	function automatic walk_result_t walk_step(input logic rt, input logic [VA_W-1:0] va,
		input logic [ENTRY_W-1:0] ent);
		walk_result_t r;
		r = '0;
		r.kind = KIND_READ;
		if (!rt) begin
			// A request always restarts from the top table, abandoning any walk.
			pred_virt = va;
			pred_level = LVL_PML4;
			pred_busy = 1'b1;
			r.mem_addr = {pred_root[PA_W-1:12], table_index(va, LVL_PML4), 3'b000};
		end else if (!pred_busy) begin
			r.kind = KIND_IDLE;
		end else if (!ent[BIT_PRESENT]) begin
			// Only a non-present last-level entry still reports its flag bits.
			r.kind = KIND_DONE;
			r.fault = 1'b1;
			if (pred_level == LVL_PT) begin
				r.flags_low = ent[11:0];
				r.flags_high = ent[63:52];
			end
			pred_busy = 1'b0;
			pred_level = LVL_PML4;
		end else if (pred_level == LVL_PD && ent[BIT_SIZE]) begin
			r.kind = KIND_DONE;
			r.phys_addr = {ent[51:21], pred_virt[20:0]};
			r.flags_low = ent[11:0];
			r.flags_high = ent[63:52];
			r.huge_page = 1'b1;
			pred_busy = 1'b0;
			pred_level = LVL_PML4;
		end else if (pred_level == LVL_PT) begin
			r.kind = KIND_DONE;
			r.phys_addr = {ent[51:12], pred_virt[11:0]};
			r.flags_low = ent[11:0];
			r.flags_high = ent[63:52];
			pred_busy = 1'b0;
			pred_level = LVL_PML4;
		end else begin
			// Upper levels, the PDPT size bit included, point to the next table.
			pred_level = pred_level + 2'd1;
			r.mem_addr = {ent[51:12], table_index(pred_virt, pred_level), 3'b000};
		end
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
			mismatches++;
		end
	endtask

	// Compare taken result words first, then predict the word taken at this edge.
	always @(posedge clk or negedge arst_n) begin : watch
		walk_result_t want;
		if (!arst_n) begin
			pred_busy = 1'b0;
			pred_level = LVL_PML4;
			pred_virt = '0;
			pred_root = '0;
			expected_words.delete();
			mismatches = 0;
			words_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with none expected, kind %h", $time, out_kind);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					compare_field("out_kind", 64'(want.kind), 64'(out_kind));
					compare_field("mem_addr", 64'(want.mem_addr), 64'(mem_addr));
					compare_field("phys_addr", 64'(want.phys_addr), 64'(phys_addr));
					compare_field("flags_low", 64'(want.flags_low), 64'(flags_low));
					compare_field("flags_high", 64'(want.flags_high), 64'(flags_high));
					compare_field("fault", 64'(want.fault), 64'(fault));
					compare_field("huge_page", 64'(want.huge_page), 64'(huge_page));
				end
			end
			if (cfg_wr_en)
				pred_root = cfg_wr_data;
			if (in_valid && in_ready)
				expected_words.push_back(walk_step(req_type, virt_addr, entry_data));
			words_pending <= expected_words.size();
		end
	end

endmodule

FILE: tb/four_level_page_table_walker_core_tb.sv
// Testbench top for the four-level page table walker: drives requests and table
// entries, stalls the result side and gives the verdict.
// Depends on ptw_pkg, four_level_page_table_walker_core and ptw_walk_checker.
`timescale 1ns / 1ps

module four_level_page_table_walker_core_tb;
	import ptw_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                req_type = 1'b0;
	logic [VA_W-1:0]     virt_addr = '0;
	logic [ENTRY_W-1:0]  entry_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b1;
	logic [1:0]          out_kind;
	logic [PA_W-1:0]     mem_addr;
	logic [PA_W-1:0]     phys_addr;
	logic [FLAG_W-1:0]   flags_low;
	logic [FLAG_W-1:0]   flags_high;
	logic                fault;
	logic                huge_page;
	logic                cfg_wr_en = 1'b0;
	logic [PA_W-1:0]     cfg_wr_data = '0;
	int                  fail_count;
	int                  words_pending;

	// Chance in percent of a sender gap before each word, and of a receiver stall at each turn of the result side.
	int                  idle_pct = 0;
	int                  stall_pct = 0;

	four_level_page_table_walker_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.virt_addr  (virt_addr),
		.entry_data (entry_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.mem_addr   (mem_addr),
		.phys_addr  (phys_addr),
		.flags_low  (flags_low),
		.flags_high (flags_high),
		.fault      (fault),
		.huge_page  (huge_page),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	ptw_walk_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.virt_addr    (virt_addr),
		.entry_data   (entry_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.mem_addr     (mem_addr),
		.phys_addr    (phys_addr),
		.flags_low    (flags_low),
		.flags_high   (flags_high),
		.fault        (fault),
		.huge_page    (huge_page),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.words_pending(words_pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Offers one word, after an optional gap, and waits until it is taken.
	task automatic send_word(input logic rt, input logic [VA_W-1:0] va,
		input logic [ENTRY_W-1:0] ent);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		virt_addr <= va;
		entry_data <= ent;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds the sender until every expected result word has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic write_root(input logic [PA_W-1:0] base);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= base;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One walk: a request and the entries that memory would return for it.
	// Now and then a walk is cut short, or a stray word comes around it.
	task automatic run_walk(inout int walk_words);
		logic [VA_W-1:0]    va;
		logic [ENTRY_W-1:0] ent;
		int                 lvl;
		int                 cut;
		if ($urandom_range(0, 19) == 0)
			send_word(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
				{$urandom, $urandom});
		va = 48'({$urandom, $urandom});
		send_word(1'b0, va, {$urandom, $urandom});
		walk_words++;
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : 4;
		for (lvl = 0; lvl < cut; lvl++) begin
			ent = {$urandom, $urandom};
			ent[BIT_PRESENT] = ($urandom_range(0, 99) >= 6);
			if (lvl == LVL_PD)
				ent[BIT_SIZE] = ($urandom_range(0, 99) < 35);
			send_word(1'b1, 48'({$urandom, $urandom}), ent);
			walk_words++;
			if (!ent[BIT_PRESENT] || (lvl == LVL_PD && ent[BIT_SIZE]))
				break;
		end
		if ($urandom_range(0, 14) == 0)
			send_word(1'b1, 48'({$urandom, $urandom}), {$urandom, $urandom});
	endtask

	// Result side: random stall bursts on out_ready.
	initial begin : result_side
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int              phase;
		int              walk_words;
		logic [PA_W-1:0] base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the highest root base, low bits set as well.
		write_root('1);
		stall_pct = 20;
		send_word(1'b1, '0, '1);
		// Walk to a 4 KiB page; the PDPT size bit must be followed as a pointer.
		send_word(1'b0, '1, '0);
		send_word(1'b1, '0, '1);
		send_word(1'b1, '0, '1);
		send_word(1'b1, '0, ~64'h80);
		send_word(1'b1, '0, '1);
		// Walk to a 2 MiB page at address zero.
		send_word(1'b0, '0, '0);
		send_word(1'b1, '0, 64'h1);
		send_word(1'b1, '0, 64'h1);
		send_word(1'b1, '0, 64'hFFF0_0000_0000_0FFF);
		// Fault at the top table.
		send_word(1'b0, 48'h8000_0000_0000, '0);
		send_word(1'b1, '0, '0);
		// Fault at the last level still shows the flag bits.
		send_word(1'b0, 48'h5555_5555_5555, '0);
		send_word(1'b1, '0, 64'h0000_0000_0000_1001);
		send_word(1'b1, '0, 64'h000F_FFFF_FFFF_F001);
		send_word(1'b1, '0, 64'h1);
		send_word(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFFE);
		// A new request while a walk is in progress.
		send_word(1'b0, 48'hAAAA_AAAA_AAAA, '0);
		send_word(1'b1, '0, 64'h0123_4567_89AB_C001);
		send_word(1'b0, 48'h1234_5678_9ABC, '0);
		send_word(1'b1, '0, '0);
		// An entry after the walk has ended.
		send_word(1'b1, '0, '1);

		// Random phases, each with its root base and idling mix set anew.
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1:       base = '1;
				2:       base = '0;
				default: base = 52'({$urandom, $urandom});
			endcase
			write_root(base);
			case (phase)
				0:       begin idle_pct = 25; stall_pct = 25; end
				2:       begin idle_pct = 50; stall_pct = 40; end
				3:       begin idle_pct = 15; stall_pct = 15; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			walk_words = 0;
			while (walk_words < 220) begin
				run_walk(walk_words);
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_step.sv
hw/rtl/four_level_page_table_walker_core.sv
tb/ptw_walk_checker.sv
tb/four_level_page_table_walker_core_tb.sv
